// ===== sv/nsf_pkg.sv =====
// Shared types and constants for the NMEA sentence framer.
// Used by nsf_ctrl, nsf_datapath and nmea_sentence_framer_top; depends on nothing.
`default_nettype none

package nsf_pkg;

	localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam int unsigned MIN_GAP     = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHOW
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // take the byte on the input channel
		logic start_emit;  // load the read pointer for a sentence
		logic rd_en;       // read the store at the read pointer
		logic advance;     // current output beat was taken
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit_req;    // input byte ends a sentence long enough to send
		logic at_last;     // read pointer sits on the sentence's final byte
	} status_t;

endpackage

`default_nettype wire

// ===== sv/nsf_ctrl.sv =====
// Controller state machine for the NMEA sentence framer.
// Depends on nsf_pkg for the state, command and status types.
`default_nettype none

module nsf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rx_valid,
	output logic                  rx_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire nsf_pkg::status_t status,
	output nsf_pkg::cmd_t         cmd
);

	nsf_pkg::state_t state_q;
	nsf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			nsf_pkg::ST_IDLE: begin
				if (rx_valid && status.emit_req) begin
					state_d = nsf_pkg::ST_READ;
				end
			end
			nsf_pkg::ST_READ: begin
				state_d = nsf_pkg::ST_SHOW;
			end
			nsf_pkg::ST_SHOW: begin
				if (!out_stall) begin
					state_d = status.at_last ? nsf_pkg::ST_IDLE : nsf_pkg::ST_READ;
				end
			end
			default: begin
				state_d = nsf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		rx_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			nsf_pkg::ST_IDLE: begin
				rx_stall       = 1'b0;
				cmd.accept     = rx_valid;
				cmd.start_emit = rx_valid && status.emit_req;
			end
			nsf_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			nsf_pkg::ST_SHOW: begin
				out_valid   = 1'b1;
				cmd.advance = !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/nsf_datapath.sv =====
// Datapath of the NMEA sentence framer: line store, fill and start
// counters, read pointer and output register. Depends on nsf_pkg.
`default_nettype none

module nsf_datapath #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       rx_byte,
	input  wire nsf_pkg::cmd_t    cmd,
	output nsf_pkg::status_t      status,
	output logic [7:0]            out_byte,
	output logic                  first_byte,
	output logic                  last_byte
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);
	localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
	localparam logic [CW-1:0] GAP_C   = CW'(nsf_pkg::MIN_GAP);

	logic [7:0]    store_q [BUFFER_DEPTH];
	logic [CW-1:0] fill_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] end_q;
	logic          first_q;
	logic [7:0]    rd_data_q;

	logic          eff_empty;
	logic          is_dollar;
	logic          is_newline;
	logic [CW-1:0] gap;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] last_idx;

	// A full buffer is flushed before the byte is looked at.
	assign eff_empty  = (fill_q == '0) || (fill_q == DEPTH_C);
	assign is_dollar  = (rx_byte == nsf_pkg::CHAR_DOLLAR);
	assign is_newline = (rx_byte == nsf_pkg::CHAR_NEWLINE);
	assign gap        = fill_q - CW'(start_q);
	assign last_idx   = fill_q - CW'(2);

	assign status.emit_req = !eff_empty && is_newline && (gap > GAP_C);
	assign status.at_last  = (rd_ptr_q == end_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		if (cmd.accept) begin
			if (eff_empty) begin
				wr_en = is_dollar;
			end else if (!is_newline) begin
				wr_en   = 1'b1;
				wr_addr = fill_q[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			start_q <= '0;
		end else if (cmd.accept) begin
			if (eff_empty) begin
				start_q <= '0;
				fill_q  <= is_dollar ? CW'(1) : '0;
			end else if (is_newline) begin
				start_q <= '0;
				fill_q  <= '0;
			end else begin
				if (is_dollar) begin
					start_q <= fill_q[AW-1:0];
				end
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_data_q <= store_q[rd_ptr_q];
		end
	end

	// The read pointer walks from the sentence's '$' to the byte before the CR.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			end_q    <= '0;
			first_q  <= 1'b0;
		end else if (cmd.start_emit) begin
			rd_ptr_q <= start_q;
			end_q    <= last_idx[AW-1:0];
			first_q  <= 1'b1;
		end else if (cmd.advance) begin
			rd_ptr_q <= rd_ptr_q + AW'(1);
			first_q  <= 1'b0;
		end
	end

	assign out_byte   = rd_data_q;
	assign first_byte = first_q;
	assign last_byte  = status.at_last;

endmodule

`default_nettype wire

// ===== sv/nmea_sentence_framer_top.sv =====
// NMEA sentence framer: takes received bytes on rx_byte and sends
// framed sentences starting with '$' on out_byte, first_byte, last_byte.
// Each channel moves one beat when its valid is high and its stall is low.
// A byte that does not end a sentence is taken at once and, after a '$'
// has opened a sentence, stored; the block then stays ready for more bytes.
// A newline that closes a long enough sentence starts an emission: each
// byte, the first included, is read from the line store into the output
// register (ST_READ) and then offered there (ST_SHOW); the next byte is
// read only after the previous beat is taken.
// While a sentence is being sent, rx_stall stays high.
// When out_stall is high, the current output beat holds unchanged until
// it is taken; nothing is lost.
// Reset empties the buffer and returns the controller to idle; the store
// itself is not cleared, only entries written since the last '$' are read.
`default_nettype none

module nmea_sentence_framer_top #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            first_byte,
	output logic            last_byte
);

	nsf_pkg::cmd_t    cmd;
	nsf_pkg::status_t status;

	nsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	nsf_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.status     (status),
		.out_byte   (out_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire
